// ===== design/bgpm_pkg.sv =====
// Shared constants and codes for the binary greedy plane mesher.
`default_nettype none

package bgpm_pkg;

  // Default edge length of the square bit plane.
  localparam int PLANE_SIZE_DEF = 64;

  // Fixed field widths of the request and result words.
  localparam int ROW_BITS_W = 64;
  localparam int ROW_IDX_W  = 6;
  localparam int NORMAL_W   = 3;
  localparam int COORD_W    = 6;
  localparam int AXIS_W     = 2;
  localparam int LEN_W      = 7;
  localparam int NUM_W      = 12;

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_QUAD = 1'b1;

  // Axis codes.
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // Normals at or above this code swap width and height.
  localparam logic [NORMAL_W-1:0] NORMAL_SWAP = 3'd2;

  // Quad counter saturates here.
  localparam logic [NUM_W-1:0] COUNT_MAX = 12'd4095;

endpackage

`default_nettype wire

// ===== design/bgpm_channels.sv =====
// Request and result channel interfaces of the plane mesher.
`default_nettype none

interface bgpm_in_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [bgpm_pkg::ROW_IDX_W-1:0]  row_index;
  logic [bgpm_pkg::ROW_BITS_W-1:0] row_bits;
  logic [bgpm_pkg::NORMAL_W-1:0]   normal;
  logic [bgpm_pkg::ROW_IDX_W-1:0]  slice;
  logic [bgpm_pkg::AXIS_W-1:0]     u_axis;
  logic [bgpm_pkg::AXIS_W-1:0]     v_axis;
  logic [bgpm_pkg::AXIS_W-1:0]     w_axis;

  modport source (
    output valid, req_type, row_index, row_bits, normal, slice, u_axis, v_axis, w_axis,
    input  ready
  );
  modport sink (
    input  valid, req_type, row_index, row_bits, normal, slice, u_axis, v_axis, w_axis,
    output ready
  );
endinterface

interface bgpm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [bgpm_pkg::COORD_W-1:0]  coord_x;
  logic [bgpm_pkg::COORD_W-1:0]  coord_y;
  logic [bgpm_pkg::COORD_W-1:0]  coord_z;
  logic [bgpm_pkg::LEN_W-1:0]    quad_width;
  logic [bgpm_pkg::LEN_W-1:0]    quad_height;
  logic [bgpm_pkg::NORMAL_W-1:0] quad_normal;
  logic [bgpm_pkg::NUM_W-1:0]    quad_number;

  modport source (
    output valid, found, coord_x, coord_y, coord_z, quad_width, quad_height,
           quad_normal, quad_number,
    input  ready
  );
  modport sink (
    input  valid, found, coord_x, coord_y, coord_z, quad_width, quad_height,
           quad_normal, quad_number,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/binary_greedy_plane_mesher_unit.sv =====
// Top level of the binary greedy plane mesher: request handling, quad sequencer, result register.
`default_nettype none

// A load word writes one plane row in the cycle it is accepted; loading row 0
// also restarts the plane (scan position and quad counter go to zero). A quad
// request runs a sequencer around the single read port of the row memory and
// one shared adder and bit encoder: it accepts the request, starts the scan,
// scans rows until one holds a set bit, isolates the lowest set bit and its run
// (negate, mask and run states), tries the following rows for extension, and
// posts the result. Rows scanned plus rows tried never exceed PLANE_SIZE; an
// exhausted plane skips the bit isolation. Posting waits while the result
// register still holds an unaccepted word.
// The block takes no new word while a quad request is in flight; the result
// sits in an output register, so a stalled result does not hold back loads.
// Exactly one result word follows each quad request, none follows a load.
module binary_greedy_plane_mesher_unit #(
  parameter int PLANE_SIZE = bgpm_pkg::PLANE_SIZE_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bgpm_in_if.sink     in_ch,
  bgpm_out_if.source  out_ch
);

  localparam int IDX_W  = $clog2(PLANE_SIZE);
  localparam int CNT_W  = $clog2(PLANE_SIZE + 1);
  localparam int RIDX_W = bgpm_pkg::ROW_IDX_W + 1;
  localparam logic [CNT_W-1:0]  PLANE_LIM   = CNT_W'(PLANE_SIZE);
  localparam logic [RIDX_W-1:0] LOAD_LIM    = RIDX_W'(PLANE_SIZE);
  localparam logic [bgpm_pkg::LEN_W-1:0] FULL_LEN = bgpm_pkg::LEN_W'(PLANE_SIZE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_NEG,
    S_MASK,
    S_RUN,
    S_EXT_CHK,
    S_EMIT
  } state_t;

  state_t state_r;

  logic [CNT_W-1:0]              scan_row_r;
  logic [bgpm_pkg::NUM_W-1:0]    quad_count_r;
  logic                          found_r;
  logic [PLANE_SIZE-1:0]         row_r;
  logic [PLANE_SIZE-1:0]         lsb_r;
  logic [PLANE_SIZE-1:0]         umask_r;
  logic [PLANE_SIZE-1:0]         end_r;
  logic [IDX_W-1:0]              u_r;
  logic [IDX_W-1:0]              v_r;
  logic [CNT_W-1:0]              ext_row_r;
  logic [bgpm_pkg::LEN_W-1:0]    w_r;
  logic [bgpm_pkg::LEN_W-1:0]    h_r;
  logic [bgpm_pkg::NORMAL_W-1:0] normal_r;
  logic [bgpm_pkg::ROW_IDX_W-1:0] slice_r;
  logic [bgpm_pkg::AXIS_W-1:0]   ua_r;
  logic [bgpm_pkg::AXIS_W-1:0]   va_r;
  logic [bgpm_pkg::AXIS_W-1:0]   wa_r;

  logic                          out_valid_r;
  logic                          out_found_r;
  logic [bgpm_pkg::COORD_W-1:0]  out_x_r;
  logic [bgpm_pkg::COORD_W-1:0]  out_y_r;
  logic [bgpm_pkg::COORD_W-1:0]  out_z_r;
  logic [bgpm_pkg::LEN_W-1:0]    out_w_r;
  logic [bgpm_pkg::LEN_W-1:0]    out_h_r;
  logic [bgpm_pkg::NORMAL_W-1:0] out_normal_r;
  logic [bgpm_pkg::NUM_W-1:0]    out_number_r;

  // memory ports
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [PLANE_SIZE-1:0] wr_data;
  logic [CNT_W-1:0]      rd_row;
  logic [PLANE_SIZE-1:0] rd_data;

  // shared adder and bit encoder
  logic [PLANE_SIZE-1:0] add_a;
  logic [PLANE_SIZE-1:0] add_b;
  logic [PLANE_SIZE-1:0] add_sum;
  logic [PLANE_SIZE-1:0] enc_in;
  logic [IDX_W-1:0]      enc_idx;

  logic [CNT_W-1:0]      scan_nxt;
  logic [CNT_W-1:0]      v_ext;
  logic [CNT_W-1:0]      ext_nxt;
  logic                  ext_hit;
  logic                  in_acc;
  logic                  load_acc;
  logic                  load_in_range;
  logic                  out_free;
  logic                  swap;
  logic [bgpm_pkg::COORD_W-1:0] u_coord;
  logic [bgpm_pkg::COORD_W-1:0] v_coord;

  function automatic logic [bgpm_pkg::COORD_W-1:0] map_coord(
    input logic [bgpm_pkg::AXIS_W-1:0]  axis,
    input logic [bgpm_pkg::AXIS_W-1:0]  ua,
    input logic [bgpm_pkg::AXIS_W-1:0]  va,
    input logic [bgpm_pkg::AXIS_W-1:0]  wa,
    input logic [bgpm_pkg::COORD_W-1:0] u,
    input logic [bgpm_pkg::COORD_W-1:0] v,
    input logic [bgpm_pkg::COORD_W-1:0] s
  );
    logic [bgpm_pkg::COORD_W-1:0] c;
    // slice has priority, then row, then column
    if (wa == axis) begin
      c = s;
    end else if (va == axis) begin
      c = v;
    end else if (ua == axis) begin
      c = u;
    end else begin
      c = '0;
    end
    return c;
  endfunction

  assign in_acc        = in_ch.valid && in_ch.ready;
  assign load_acc      = in_acc && (in_ch.req_type == bgpm_pkg::REQ_LOAD);
  assign load_in_range = {1'b0, in_ch.row_index} < LOAD_LIM;
  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_free      = !out_valid_r || out_ch.ready;

  assign scan_nxt = scan_row_r + CNT_W'(1);
  assign v_ext    = CNT_W'(v_r) + CNT_W'(1);
  assign ext_nxt  = ext_row_r + CNT_W'(1);
  assign ext_hit  = ((rd_data & umask_r) == umask_r);

  assign add_a   = (state_r == S_NEG) ? ~row_r : row_r;
  assign add_b   = (state_r == S_NEG) ? PLANE_SIZE'(1) : lsb_r;
  assign add_sum = add_a + add_b;
  assign enc_in  = (state_r == S_MASK) ? lsb_r : end_r;

  always_comb begin
    enc_idx = '0;
    for (int i = 0; i < PLANE_SIZE; i++) begin
      if (enc_in[i]) begin
        enc_idx = enc_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = in_ch.row_index[IDX_W-1:0];
    wr_data = in_ch.row_bits[PLANE_SIZE-1:0];
    rd_row  = scan_row_r;
    unique case (state_r)
      S_IDLE: begin
        wr_en = load_acc && load_in_range;
      end
      S_SCAN_CHK: begin
        rd_row = scan_nxt;
      end
      S_RUN: begin
        wr_en   = 1'b1;
        wr_addr = v_r;
        wr_data = row_r & ~umask_r;
        rd_row  = v_ext;
      end
      S_EXT_CHK: begin
        wr_en   = ext_hit;
        wr_addr = ext_row_r[IDX_W-1:0];
        wr_data = rd_data & ~umask_r;
        rd_row  = ext_nxt;
      end
      default: begin
        rd_row = scan_row_r;
      end
    endcase
  end

  bgpm_row_store #(
    .DEPTH (PLANE_SIZE),
    .WIDTH (PLANE_SIZE)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_row[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign swap    = (normal_r >= bgpm_pkg::NORMAL_SWAP);
  assign u_coord = bgpm_pkg::COORD_W'(u_r);
  assign v_coord = bgpm_pkg::COORD_W'(v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      scan_row_r   <= '0;
      quad_count_r <= '0;
    end else begin
      // the emit state reloads the result register itself
      if (out_valid_r && out_ch.ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.req_type == bgpm_pkg::REQ_LOAD) begin
              if (in_ch.row_index == '0) begin
                scan_row_r   <= '0;
                quad_count_r <= '0;
              end
            end else begin
              normal_r <= in_ch.normal;
              slice_r  <= in_ch.slice;
              ua_r     <= in_ch.u_axis;
              va_r     <= in_ch.v_axis;
              wa_r     <= in_ch.w_axis;
              found_r  <= 1'b0;
              state_r  <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          if (scan_row_r >= PLANE_LIM) begin
            state_r <= S_EMIT;
          end else begin
            state_r <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          // skip empty rows, one per cycle
          if (rd_data == '0) begin
            scan_row_r <= scan_nxt;
            if (scan_nxt >= PLANE_LIM) begin
              state_r <= S_EMIT;
            end
          end else begin
            row_r   <= rd_data;
            v_r     <= scan_row_r[IDX_W-1:0];
            state_r <= S_NEG;
          end
        end
        S_NEG: begin
          // isolate lowest set bit
          lsb_r   <= row_r & add_sum;
          state_r <= S_MASK;
        end
        S_MASK: begin
          // adding the low bit ripples through the run and lands just past it
          umask_r <= row_r & ~add_sum;
          end_r   <= add_sum & ~row_r;
          u_r     <= enc_idx;
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (end_r == '0) begin
            w_r <= FULL_LEN - bgpm_pkg::LEN_W'(u_r);
          end else begin
            w_r <= bgpm_pkg::LEN_W'(enc_idx) - bgpm_pkg::LEN_W'(u_r);
          end
          h_r       <= bgpm_pkg::LEN_W'(1);
          ext_row_r <= v_ext;
          found_r   <= 1'b1;
          if (v_ext >= PLANE_LIM) begin
            state_r <= S_EMIT;
          end else begin
            state_r <= S_EXT_CHK;
          end
        end
        S_EXT_CHK: begin
          if (ext_hit) begin
            h_r       <= h_r + bgpm_pkg::LEN_W'(1);
            ext_row_r <= ext_nxt;
            if (ext_nxt >= PLANE_LIM) begin
              state_r <= S_EMIT;
            end
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_found_r <= found_r;
            if (found_r) begin
              out_x_r      <= map_coord(bgpm_pkg::AXIS_X, ua_r, va_r, wa_r,
                                        u_coord, v_coord, slice_r);
              out_y_r      <= map_coord(bgpm_pkg::AXIS_Y, ua_r, va_r, wa_r,
                                        u_coord, v_coord, slice_r);
              out_z_r      <= map_coord(bgpm_pkg::AXIS_Z, ua_r, va_r, wa_r,
                                        u_coord, v_coord, slice_r);
              out_w_r      <= swap ? h_r : w_r;
              out_h_r      <= swap ? w_r : h_r;
              out_normal_r <= normal_r;
              out_number_r <= quad_count_r;
              if (quad_count_r != bgpm_pkg::COUNT_MAX) begin
                quad_count_r <= quad_count_r + bgpm_pkg::NUM_W'(1);
              end
            end else begin
              out_x_r      <= '0;
              out_y_r      <= '0;
              out_z_r      <= '0;
              out_w_r      <= '0;
              out_h_r      <= '0;
              out_normal_r <= '0;
              out_number_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.coord_x     = out_x_r;
  assign out_ch.coord_y     = out_y_r;
  assign out_ch.coord_z     = out_z_r;
  assign out_ch.quad_width  = out_w_r;
  assign out_ch.quad_height = out_h_r;
  assign out_ch.quad_normal = out_normal_r;
  assign out_ch.quad_number = out_number_r;

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_row_r <= PLANE_LIM)
    else $error("scan row ran past the plane");

  a_lsb_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MASK) |-> $onehot(lsb_r))
    else $error("isolated low bit is not one-hot");

  a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXT_CHK) |-> (umask_r != '0))
    else $error("extending an empty run");

  a_ext_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXT_CHK) |->
      ((CNT_W + 1)'(v_r) + (CNT_W + 1)'(h_r) == (CNT_W + 1)'(ext_row_r)) &&
      (ext_row_r < PLANE_LIM))
    else $error("extension row out of step with height");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (load_acc && (in_ch.row_index == '0)) |=>
      ((scan_row_r == '0) && (quad_count_r == '0)))
    else $error("row 0 load did not restart the plane");

endmodule

`default_nettype wire

// ===== design/bgpm_row_store.sv =====
// Plane row memory: one write port, one read port with registered data.
`default_nettype none

module bgpm_row_store #(
  parameter int  DEPTH  = bgpm_pkg::PLANE_SIZE_DEF,
  parameter int  WIDTH  = bgpm_pkg::PLANE_SIZE_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== verif/mesher_scoreboard.sv =====
// Word types and the quad scoreboard used by the plane mesher testbench.
package mesher_tb_pkg;
  import bgpm_pkg::*;

  // Axis code that places its coordinate nowhere.
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  typedef struct packed {
    logic                  req_type;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic [NORMAL_W-1:0]   normal;
    logic [ROW_IDX_W-1:0]  slice;
    logic [AXIS_W-1:0]     u_axis;
    logic [AXIS_W-1:0]     v_axis;
    logic [AXIS_W-1:0]     w_axis;
  } mesh_word_t;

  typedef struct packed {
    logic                found;
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic [COORD_W-1:0]  coord_z;
    logic [LEN_W-1:0]    quad_width;
    logic [LEN_W-1:0]    quad_height;
    logic [NORMAL_W-1:0] quad_normal;
    logic [NUM_W-1:0]    quad_number;
  } quad_word_t;

  class quad_scoreboard;
    logic [ROW_BITS_W-1:0] plane_rows [PLANE_SIZE_DEF];
    int unsigned           scan_row;
    logic [NUM_W-1:0]      quad_count;
    quad_word_t            expected_quads [$];
    int                    errors;
    int                    loads_seen;
    int                    quads_seen;
    int                    found_seen;
    int                    exhausted_seen;

    function new();
      foreach (plane_rows[i]) plane_rows[i] = '0;
      scan_row       = 0;
      quad_count     = '0;
      errors         = 0;
      loads_seen     = 0;
      quads_seen     = 0;
      found_seen     = 0;
      exhausted_seen = 0;
    endfunction

    function int pending();
      return expected_quads.size();
    endfunction

    // True when no face bit is left at or after the scan position.
    function bit plane_empty();
      for (int v = scan_row; v < PLANE_SIZE_DEF; v++) begin
        if (plane_rows[v] != '0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function quad_word_t mesh_next(mesh_word_t req);
      quad_word_t            q;
      int unsigned           v;
      int unsigned           u;
      int unsigned           run;
      int unsigned           h;
      int unsigned           b;
      logic [ROW_BITS_W-1:0] row;
      logic [ROW_BITS_W-1:0] umask;
      int unsigned           coords [4];

      q = '0;
      v = scan_row;
      while (v < PLANE_SIZE_DEF && plane_rows[v] == '0) v++;
      scan_row = v;
      if (v >= PLANE_SIZE_DEF) return q;

      row = plane_rows[v];
      u = 0;
      while (u < 63 && !row[u]) u++;
      run = 0;
      b = u;
      while (b < PLANE_SIZE_DEF && row[b]) begin
        run++;
        b++;
      end
      umask = (run >= 64) ? '1 : (((64'd1 << run) - 64'd1) << u);

      // Grow downward while the next row holds the whole run.
      h = 1;
      while (v + h < PLANE_SIZE_DEF && (plane_rows[v + h] & umask) == umask) begin
        plane_rows[v + h] &= ~umask;
        h++;
      end
      plane_rows[v] &= ~umask;

      coords = '{0, 0, 0, 0};
      coords[req.u_axis] = u;
      coords[req.v_axis] = v;
      coords[req.w_axis] = 32'(req.slice);

      q.found       = 1'b1;
      q.coord_x     = COORD_W'(coords[0]);
      q.coord_y     = COORD_W'(coords[1]);
      q.coord_z     = COORD_W'(coords[2]);
      q.quad_width  = (req.normal >= NORMAL_SWAP) ? LEN_W'(h) : LEN_W'(run);
      q.quad_height = (req.normal >= NORMAL_SWAP) ? LEN_W'(run) : LEN_W'(h);
      q.quad_normal = req.normal;
      q.quad_number = quad_count;
      if (quad_count < COUNT_MAX) quad_count++;
      return q;
    endfunction

    function void note_word(mesh_word_t w);
      if (w.req_type == REQ_LOAD) begin
        loads_seen++;
        if (w.row_index == '0) begin
          scan_row   = 0;
          quad_count = '0;
        end
        plane_rows[w.row_index] = w.row_bits;
      end else begin
        quads_seen++;
        expected_quads.push_back(mesh_next(w));
      end
    endfunction

    function bit field_ok(string name, logic [NUM_W-1:0] exp_v, logic [NUM_W-1:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_quad(quad_word_t got);
      quad_word_t exp_q;
      bit         ok;

      if (expected_quads.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, got found=%0b x=%0d y=%0d z=%0d",
                 $time, got.found, got.coord_x, got.coord_y, got.coord_z);
        return;
      end
      exp_q = expected_quads.pop_front();
      ok = 1'b1;
      ok &= field_ok("found", NUM_W'(exp_q.found), NUM_W'(got.found));
      ok &= field_ok("coord_x", NUM_W'(exp_q.coord_x), NUM_W'(got.coord_x));
      ok &= field_ok("coord_y", NUM_W'(exp_q.coord_y), NUM_W'(got.coord_y));
      ok &= field_ok("coord_z", NUM_W'(exp_q.coord_z), NUM_W'(got.coord_z));
      ok &= field_ok("quad_width", NUM_W'(exp_q.quad_width), NUM_W'(got.quad_width));
      ok &= field_ok("quad_height", NUM_W'(exp_q.quad_height), NUM_W'(got.quad_height));
      ok &= field_ok("quad_normal", NUM_W'(exp_q.quad_normal), NUM_W'(got.quad_normal));
      ok &= field_ok("quad_number", exp_q.quad_number, got.quad_number);
      if (!ok) errors++;
      if (exp_q.found) found_seen++;
      else exhausted_seen++;
    endfunction
  endclass
endpackage

// ===== verif/testbench.sv =====
// Testbench top: drives load and quad words into the plane mesher and checks every quad.
module testbench;
  import bgpm_pkg::*;
  import mesher_tb_pkg::*;

  localparam int RANDOM_ITEMS   = 1750;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 2 * PLANE_SIZE_DEF + 16;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bgpm_in_if  in_ch ();
  bgpm_out_if out_ch ();

  binary_greedy_plane_mesher_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  quad_scoreboard sb;
  mesh_word_t     seen_word;
  quad_word_t     seen_quad;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int planes_run     = 0;
  int quiet_cycles   = 0;

  always #5 clk = ~clk;

  // Result side: random stalls, or a long hold when one is requested.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        seen_word.req_type  = in_ch.req_type;
        seen_word.row_index = in_ch.row_index;
        seen_word.row_bits  = in_ch.row_bits;
        seen_word.normal    = in_ch.normal;
        seen_word.slice     = in_ch.slice;
        seen_word.u_axis    = in_ch.u_axis;
        seen_word.v_axis    = in_ch.v_axis;
        seen_word.w_axis    = in_ch.w_axis;
        sb.note_word(seen_word);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        seen_quad.found       = out_ch.found;
        seen_quad.coord_x     = out_ch.coord_x;
        seen_quad.coord_y     = out_ch.coord_y;
        seen_quad.coord_z     = out_ch.coord_z;
        seen_quad.quad_width  = out_ch.quad_width;
        seen_quad.quad_height = out_ch.quad_height;
        seen_quad.quad_normal = out_ch.quad_normal;
        seen_quad.quad_number = out_ch.quad_number;
        sb.check_quad(seen_quad);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic [ROW_BITS_W-1:0] rand_row();
    int                    kind;
    int                    start;
    int                    len;
    logic [ROW_BITS_W-1:0] r;

    kind  = $urandom_range(5);
    start = $urandom_range(63);
    len   = $urandom_range(64 - start, 1);
    case (kind)
      0: r = {$urandom, $urandom};
      1: r = '1;
      2: r = 64'd1 << start;
      3: r = (len == 64) ? '1 : (((64'd1 << len) - 64'd1) << start);
      4: r = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Call at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input mesh_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= w.req_type;
    in_ch.row_index <= w.row_index;
    in_ch.row_bits  <= w.row_bits;
    in_ch.normal    <= w.normal;
    in_ch.slice     <= w.slice;
    in_ch.u_axis    <= w.u_axis;
    in_ch.v_axis    <= w.v_axis;
    in_ch.w_axis    <= w.w_axis;
    do @(posedge clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_load(input logic [ROW_IDX_W-1:0] idx, input logic [ROW_BITS_W-1:0] bits);
    mesh_word_t w;

    w.req_type  = REQ_LOAD;
    w.row_index = idx;
    w.row_bits  = bits;
    w.normal    = NORMAL_W'($urandom_range(7));
    w.slice     = ROW_IDX_W'($urandom_range(63));
    w.u_axis    = AXIS_W'($urandom_range(3));
    w.v_axis    = AXIS_W'($urandom_range(3));
    w.w_axis    = AXIS_W'($urandom_range(3));
    send_word(w);
  endtask

  task automatic send_quad(input logic [NORMAL_W-1:0] nrm, input logic [ROW_IDX_W-1:0] slc,
                           input logic [AXIS_W-1:0] ua, input logic [AXIS_W-1:0] va,
                           input logic [AXIS_W-1:0] wa);
    mesh_word_t w;

    w.req_type  = REQ_QUAD;
    w.row_index = ROW_IDX_W'($urandom_range(63));
    w.row_bits  = {$urandom, $urandom};
    w.normal    = nrm;
    w.slice     = slc;
    w.u_axis    = ua;
    w.v_axis    = va;
    w.w_axis    = wa;
    send_word(w);
  endtask

  // Mostly a proper permutation of the axes, sometimes any codes at all.
  task automatic send_random_quad();
    int a;
    int b;

    a = $urandom_range(2);
    b = (a + 1 + $urandom_range(1)) % 3;
    if ($urandom_range(9) < 8) begin
      send_quad(NORMAL_W'($urandom_range(7)), ROW_IDX_W'($urandom_range(63)),
                AXIS_W'(a), AXIS_W'(b), AXIS_W'(3 - a - b));
    end else begin
      send_quad(NORMAL_W'($urandom_range(7)), ROW_IDX_W'($urandom_range(63)),
                AXIS_W'($urandom_range(3)), AXIS_W'($urandom_range(3)),
                AXIS_W'($urandom_range(3)));
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    int                    phase;
    int                    rows_to_load;
    int                    quad_cap;
    int                    quads_done;
    int                    row_ix;
    int                    base_items;
    logic [ROW_BITS_W-1:0] bits;

    sb = new();
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_LOAD;
    in_ch.row_index = '0;
    in_ch.row_bits  = '0;
    in_ch.normal    = '0;
    in_ch.slice     = '0;
    in_ch.u_axis    = AXIS_X;
    in_ch.v_axis    = AXIS_Y;
    in_ch.w_axis    = AXIS_Z;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Write every row before the first scan; a full plane meshes to one 64x64 quad.
    for (row_ix = 0; row_ix < PLANE_SIZE_DEF; row_ix++) send_load(ROW_IDX_W'(row_ix), '1);
    send_quad(3'd0, 6'd63, AXIS_X, AXIS_Y, AXIS_Z);
    send_quad(3'd7, 6'd0, AXIS_Z, AXIS_X, AXIS_Y);
    send_quad(3'd1, 6'd1, AXIS_X, AXIS_Y, AXIS_Z);
    send_load(6'd0, 64'h8000_0000_0000_0001);
    send_load(6'd1, 64'h0000_0000_0000_0001);
    send_load(6'd40, 64'hFFFF_0000_0000_0000);
    send_quad(3'd1, 6'd21, AXIS_X, AXIS_Y, AXIS_Z);
    // Top column alone; repeated axis and the no-axis code.
    send_quad(3'd6, 6'd42, AXIS_Z, AXIS_Z, AXIS_NONE);
    send_quad(3'd2, 6'd5, AXIS_NONE, AXIS_X, AXIS_Y);
    // Row behind the scan stays hidden until the next restart.
    send_load(6'd3, '1);
    send_quad(3'd4, 6'd9, AXIS_Y, AXIS_Z, AXIS_X);
    send_load(6'd0, '0);
    send_quad(3'd5, 6'h2A, AXIS_Y, AXIS_Z, AXIS_X);
    send_load(6'd0, 64'h5555_5555_5555_5555);
    send_load(6'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_load(6'd2, 64'h5555_5555_5555_5555);
    send_quad(3'd3, 6'd17, AXIS_Z, AXIS_Y, AXIS_X);
    send_quad(3'd0, 6'd34, AXIS_X, AXIS_Z, AXIS_Y);
    wait_drained();

    base_items = items_sent;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = HOLD_CYCLES;
        end
        1: begin
          send_idle_pct  = 86;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 86;
        end
        default: begin
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      while (items_sent - base_items < RANDOM_ITEMS * (phase + 1) / 4) begin
        planes_run++;
        bits = rand_row();
        send_load(6'd0, bits);
        row_ix = 0;
        rows_to_load = $urandom_range(10);
        repeat (rows_to_load) begin
          if (row_ix < PLANE_SIZE_DEF - 1 && $urandom_range(9) < 4) begin
            // Stack the run on the next row so the quad can grow downward.
            row_ix++;
            if ($urandom_range(1)) bits |= rand_row();
          end else begin
            row_ix = $urandom_range(PLANE_SIZE_DEF - 1, 1);
            bits   = rand_row();
          end
          send_load(ROW_IDX_W'(row_ix), bits);
        end
        quad_cap   = $urandom_range(40, 3);
        quads_done = 0;
        while (!sb.plane_empty() && quads_done < quad_cap) begin
          if ($urandom_range(19) == 0) begin
            send_load(ROW_IDX_W'($urandom_range(PLANE_SIZE_DEF - 1, 1)), rand_row());
          end else begin
            send_random_quad();
            quads_done++;
          end
        end
        repeat ($urandom_range(2)) send_random_quad();
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Run covered %0d load words and %0d quad requests over %0d random planes,",
             sb.loads_seen, sb.quads_seen, planes_run);
    $display("with %0d quads returned and %0d exhausted-plane replies.",
             sb.found_seen, sb.exhausted_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/bgpm_pkg.sv
design/bgpm_channels.sv
design/bgpm_row_store.sv
design/binary_greedy_plane_mesher_unit.sv
verif/mesher_scoreboard.sv
verif/testbench.sv
